// File: hdl/aabb_cps_pkg.sv
// shared types and codes for the rectangle table pair scan unit
package aabb_cps_pkg;

  // operation carried by each input transfer
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_SCAN   = 2'd3
  } opcode_t;

  // status reported with each result
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUP       = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_code_t;

  // field and bus widths on the stream buses
  localparam int IdBits       = 16;
  localparam int InDataBits   = 80;
  localparam int InUserBits   = 2;
  localparam int OutDataBits  = 40;
  localparam int OutUserBits  = 1;

  // commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic do_op;
    logic scan_init;
    logic load_row;
    logic pair_step;
    logic push_final;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    opcode_t op;
    logic    few_entries;
    logic    col_end;
    logic    row_end;
    logic    hit;
    logic    pend_valid;
    logic    out_free;
  } dp_stat_t;

endpackage

// File: hdl/aabb_collider_table_pair_scan_unit.sv
// top level of the rectangle table pair scan unit
// Keeps an ordered table of up to MAX_COLLIDERS centred rectangles and
// handles one input transfer at a time. Add, remove and update present their
// result from the output register once it is free; all table changes happen
// in the execute state, and the next transfer is accepted only after it. A
// scan of two or more entries steps through an acceptance, a setup step, a
// row load for each row followed by its pair steps, and a finish step, with
// the one overlap comparator, which visits one pair per cycle unless a new
// hit must wait for the output register to release the pending pair. Each
// overlapping pair is held back until the next hit or the finish so that the
// final one can carry tlast; a stalled output holds the scan. The table lives
// in flip-flops and needs no clearing pass after reset.
module aabb_collider_table_pair_scan_unit #(
  parameter int MAX_COLLIDERS = 8,
  parameter int COORD_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // collider_id[15:0], pos_x[31:16], pos_y[47:32], size_w[63:48], size_h[79:64]
  input  logic [79:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], first_id[17:2], second_id[33:18], zero fill[39:34]
  output logic [39:0] m_axis_tdata,
  // has_pair[0]
  output logic [0:0]  m_axis_tuser,
  // is_last
  output logic        m_axis_tlast
);

  aabb_cps_pkg::dp_cmd_t  cmd;
  aabb_cps_pkg::dp_stat_t stat;

  // sequencing of operations and scan
  aabb_cps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table, comparator and output register
  aabb_cps_dp #(
    .MAX_COLLIDERS (MAX_COLLIDERS),
    .COORD_BITS    (COORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata),
    .m_tuser  (m_axis_tuser),
    .m_tlast  (m_axis_tlast),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// File: hdl/aabb_cps_ctrl.sv
// controller state machine for the rectangle table pair scan unit
module aabb_cps_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  aabb_cps_pkg::dp_stat_t stat,
  output aabb_cps_pkg::dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_ROW    = 5'b00100,
    S_PAIR   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.op == aabb_cps_pkg::OP_SCAN) begin
          cmd.scan_init = 1'b1;
          state_next    = stat.few_entries ? S_FINISH : S_ROW;
        end else if (stat.out_free) begin
          cmd.do_op  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ROW: begin
        cmd.load_row = 1'b1;
        state_next   = S_PAIR;
      end
      S_PAIR: begin
        // a new hit needs the output slot to release the pending one
        if (!(stat.hit && stat.pend_valid && !stat.out_free)) begin
          cmd.pair_step = 1'b1;
          if (stat.col_end) begin
            state_next = stat.row_end ? S_FINISH : S_ROW;
          end
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.push_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/aabb_cps_dp.sv
// table storage, overlap comparator and output register of the pair scan unit
module aabb_cps_dp #(
  parameter int MAX_COLLIDERS = 8,
  parameter int COORD_BITS    = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic [aabb_cps_pkg::InDataBits-1:0]       s_tdata,
  input  logic [aabb_cps_pkg::InUserBits-1:0]       s_tuser,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  output logic [aabb_cps_pkg::OutDataBits-1:0]      m_tdata,
  output logic [aabb_cps_pkg::OutUserBits-1:0]      m_tuser,
  output logic                                      m_tlast,
  input  aabb_cps_pkg::dp_cmd_t                     cmd,
  output aabb_cps_pkg::dp_stat_t                    stat
);

  localparam int IW  = $clog2(MAX_COLLIDERS);
  localparam int CW  = $clog2(MAX_COLLIDERS + 1);
  localparam int EW  = COORD_BITS + 2;
  localparam int IDW = aabb_cps_pkg::IdBits;

  // latched input item
  aabb_cps_pkg::opcode_t          in_op;
  logic [IDW-1:0]                 in_id;
  logic signed [COORD_BITS-1:0]   in_x;
  logic signed [COORD_BITS-1:0]   in_y;
  logic [COORD_BITS-1:0]          in_w;
  logic [COORD_BITS-1:0]          in_h;

  // collider table
  logic [IDW-1:0]                 tab_id [MAX_COLLIDERS];
  logic signed [COORD_BITS-1:0]   tab_x  [MAX_COLLIDERS];
  logic signed [COORD_BITS-1:0]   tab_y  [MAX_COLLIDERS];
  logic [COORD_BITS-1:0]          tab_w  [MAX_COLLIDERS];
  logic [COORD_BITS-1:0]          tab_h  [MAX_COLLIDERS];
  logic [CW-1:0]                  count;

  // scan registers
  logic [IW-1:0]                  row_i;
  logic [IW-1:0]                  col_j;
  logic signed [EW-1:0]           a_l, a_r, a_d, a_u;
  logic [IDW-1:0]                 a_id;
  logic                           pend_valid;
  logic [IDW-1:0]                 pend_a;
  logic [IDW-1:0]                 pend_b;

  // output register
  logic                           out_valid;
  aabb_cps_pkg::status_code_t     out_status;
  logic                           out_has_pair;
  logic [IDW-1:0]                 out_first;
  logic [IDW-1:0]                 out_second;
  logic                           out_last;

  // lookup and comparator signals
  logic [MAX_COLLIDERS-1:0]       match;
  logic                           found;
  logic [IW-1:0]                  fpos;
  logic signed [EW-1:0]           b_l, b_r, b_d, b_u;
  logic                           hit;
  logic                           out_free;

  // exact edges: twice the centre minus or plus the full size
  function automatic logic signed [EW-1:0] edge_lo(logic signed [COORD_BITS-1:0] c,
                                                   logic [COORD_BITS-1:0] s);
    return (EW'(c) <<< 1) - $signed({2'b00, s});
  endfunction

  function automatic logic signed [EW-1:0] edge_hi(logic signed [COORD_BITS-1:0] c,
                                                   logic [COORD_BITS-1:0] s);
    return (EW'(c) <<< 1) + $signed({2'b00, s});
  endfunction

  function automatic logic in_closed(logic signed [EW-1:0] v, logic signed [EW-1:0] lo,
                                     logic signed [EW-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  // edges of box p tested against the intervals of box q on both axes
  function automatic logic one_way(logic signed [EW-1:0] pl, logic signed [EW-1:0] pr,
                                   logic signed [EW-1:0] pd, logic signed [EW-1:0] pu,
                                   logic signed [EW-1:0] ql, logic signed [EW-1:0] qr,
                                   logic signed [EW-1:0] qd, logic signed [EW-1:0] qu);
    logic ox;
    logic oy;
    ox = in_closed(pl, ql, qr) || in_closed(pr, ql, qr);
    oy = in_closed(pu, qd, qu) || in_closed(pd, qd, qu);
    return ox && oy;
  endfunction

  // id lookup over live entries, lowest position wins
  always_comb begin
    match = '0;
    fpos  = '0;
    for (int k = 0; k < MAX_COLLIDERS; k++) begin
      match[k] = (tab_id[k] == in_id) && (CW'(k) < count);
    end
    for (int k = MAX_COLLIDERS - 1; k >= 0; k--) begin
      if (match[k]) begin
        fpos = IW'(k);
      end
    end
  end

  assign found = |match;

  // second box of the current pair
  assign b_l = edge_lo(tab_x[col_j], tab_w[col_j]);
  assign b_r = edge_hi(tab_x[col_j], tab_w[col_j]);
  assign b_d = edge_lo(tab_y[col_j], tab_h[col_j]);
  assign b_u = edge_hi(tab_y[col_j], tab_h[col_j]);

  assign hit = one_way(a_l, a_r, a_d, a_u, b_l, b_r, b_d, b_u) ||
               one_way(b_l, b_r, b_d, b_u, a_l, a_r, a_d, a_u);

  assign out_free = !out_valid || m_tready;

  // status to controller
  always_comb begin
    stat.op          = in_op;
    stat.few_entries = (count < CW'(2));
    stat.col_end     = ((CW'(col_j) + CW'(1)) == count);
    stat.row_end     = ((CW'(row_i) + CW'(2)) == count);
    stat.hit         = hit;
    stat.pend_valid  = pend_valid;
    stat.out_free    = out_free;
  end

  // input capture, table contents and scan payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_op <= aabb_cps_pkg::opcode_t'(s_tuser[1:0]);
      in_id <= s_tdata[15:0];
      in_x  <= COORD_BITS'($signed(s_tdata[31:16]));
      in_y  <= COORD_BITS'($signed(s_tdata[47:32]));
      in_w  <= COORD_BITS'(s_tdata[63:48]);
      in_h  <= COORD_BITS'(s_tdata[79:64]);
    end
    if (cmd.do_op) begin
      unique case (in_op)
        aabb_cps_pkg::OP_ADD: begin
          if (!found && (count < CW'(MAX_COLLIDERS))) begin
            tab_id[IW'(count)] <= in_id;
            tab_x[IW'(count)]  <= in_x;
            tab_y[IW'(count)]  <= in_y;
            tab_w[IW'(count)]  <= in_w;
            tab_h[IW'(count)]  <= in_h;
          end
        end
        aabb_cps_pkg::OP_REMOVE: begin
          // later entries close up by one place
          if (found) begin
            for (int k = 0; k < MAX_COLLIDERS - 1; k++) begin
              if (IW'(k) >= fpos) begin
                tab_id[k] <= tab_id[k + 1];
                tab_x[k]  <= tab_x[k + 1];
                tab_y[k]  <= tab_y[k + 1];
                tab_w[k]  <= tab_w[k + 1];
                tab_h[k]  <= tab_h[k + 1];
              end
            end
          end
        end
        aabb_cps_pkg::OP_UPDATE: begin
          if (found) begin
            tab_x[fpos] <= in_x;
            tab_y[fpos] <= in_y;
          end
        end
        aabb_cps_pkg::OP_SCAN: begin
        end
        default: begin
        end
      endcase
    end
    if (cmd.load_row) begin
      a_l  <= edge_lo(tab_x[row_i], tab_w[row_i]);
      a_r  <= edge_hi(tab_x[row_i], tab_w[row_i]);
      a_d  <= edge_lo(tab_y[row_i], tab_h[row_i]);
      a_u  <= edge_hi(tab_y[row_i], tab_h[row_i]);
      a_id <= tab_id[row_i];
    end
    if (cmd.pair_step && hit) begin
      pend_a <= a_id;
      pend_b <= tab_id[col_j];
    end
  end

  // entry count, scan indexes and pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      row_i      <= '0;
      col_j      <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.do_op) begin
        if ((in_op == aabb_cps_pkg::OP_ADD) && !found && (count < CW'(MAX_COLLIDERS))) begin
          count <= count + CW'(1);
        end else if ((in_op == aabb_cps_pkg::OP_REMOVE) && found) begin
          count <= count - CW'(1);
        end
      end
      if (cmd.scan_init) begin
        row_i      <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.load_row) begin
        col_j <= row_i + IW'(1);
      end
      if (cmd.pair_step) begin
        if (hit) begin
          pend_valid <= 1'b1;
        end
        if (stat.col_end) begin
          row_i <= row_i + IW'(1);
        end else begin
          col_j <= col_j + IW'(1);
        end
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.do_op || cmd.push_final || (cmd.pair_step && hit && pend_valid)) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.do_op) begin
      out_has_pair <= 1'b0;
      out_first    <= '0;
      out_second   <= '0;
      out_last     <= 1'b1;
      unique case (in_op)
        aabb_cps_pkg::OP_ADD: begin
          if (found) begin
            out_status <= aabb_cps_pkg::ST_DUP;
          end else if (count >= CW'(MAX_COLLIDERS)) begin
            out_status <= aabb_cps_pkg::ST_FULL;
          end else begin
            out_status <= aabb_cps_pkg::ST_OK;
          end
        end
        aabb_cps_pkg::OP_REMOVE, aabb_cps_pkg::OP_UPDATE: begin
          out_status <= found ? aabb_cps_pkg::ST_OK : aabb_cps_pkg::ST_NOT_FOUND;
        end
        default: begin
          out_status <= aabb_cps_pkg::ST_OK;
        end
      endcase
    end else if (cmd.pair_step && hit && pend_valid) begin
      // release the previous pair, the new one is kept back
      out_status   <= aabb_cps_pkg::ST_OK;
      out_has_pair <= 1'b1;
      out_first    <= pend_a;
      out_second   <= pend_b;
      out_last     <= 1'b0;
    end else if (cmd.push_final) begin
      out_status   <= aabb_cps_pkg::ST_OK;
      out_has_pair <= pend_valid;
      out_first    <= pend_valid ? pend_a : '0;
      out_second   <= pend_valid ? pend_b : '0;
      out_last     <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b000000, out_second, out_first, out_status};
  assign m_tuser  = out_has_pair;
  assign m_tlast  = out_last;

endmodule

// File: hdl/aabb_cps_chk.sv
// port checker for the rectangle table pair scan unit, bound to the top level
module aabb_cps_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // one item at a time: no acceptance in the cycle after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while previous item still in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
       $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // a result without a pair is final and carries zero ids
  a_no_pair_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && (m_axis_tdata[33:2] == 32'd0)))
    else $error("non-pair result not final or ids nonzero");

  // pair results always report ok status
  a_pair_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[1:0] == 2'd0))
    else $error("pair result with error status");

endmodule

bind aabb_collider_table_pair_scan_unit aabb_cps_chk u_aabb_cps_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// File: tb/sv/tb.sv
// self-checking testbench for the rectangle table pair scan unit
import aabb_cps_pkg::*;

// one expected output transfer
typedef struct {
  status_code_t status;
  logic         has_pair;
  logic [15:0]  first_id;
  logic [15:0]  second_id;
  logic         last;
} scan_result_t;

// mirror of the collider table plus the queue of results still owed
class collider_scoreboard;
  localparam int Slots = 8;

  logic [15:0]        ids   [Slots];
  logic signed [15:0] cen_x [Slots];
  logic signed [15:0] cen_y [Slots];
  logic [15:0]        wid   [Slots];
  logic [15:0]        hgt   [Slots];
  int unsigned        count;
  scan_result_t       owed_q[$];
  int unsigned        errors;

  function new();
    count  = 0;
    errors = 0;
  endfunction

  function int unsigned pending();
    return owed_q.size();
  endfunction

  function int find_slot(logic [15:0] id);
    for (int i = 0; i < count; i++) begin
      if (ids[i] == id) return i;
    end
    return -1;
  endfunction

  // doubled-centre box edge, exact: 2*c - s or 2*c + s
  function logic signed [18:0] span_end(logic signed [15:0] c, logic [15:0] s, bit upper);
    logic signed [18:0] c2;
    logic signed [18:0] s2;
    c2 = c;
    c2 = c2 * 2;
    s2 = {3'b000, s};
    return upper ? c2 + s2 : c2 - s2;
  endfunction

  // edges of box a tested against the closed intervals of box b
  function bit edges_in(int a, int b);
    logic signed [18:0] al, ar, ad, au, bl, br, bd, bu;
    bit ox, oy;
    al = span_end(cen_x[a], wid[a], 1'b0);
    ar = span_end(cen_x[a], wid[a], 1'b1);
    ad = span_end(cen_y[a], hgt[a], 1'b0);
    au = span_end(cen_y[a], hgt[a], 1'b1);
    bl = span_end(cen_x[b], wid[b], 1'b0);
    br = span_end(cen_x[b], wid[b], 1'b1);
    bd = span_end(cen_y[b], hgt[b], 1'b0);
    bu = span_end(cen_y[b], hgt[b], 1'b1);
    ox = (al >= bl && al <= br) || (ar >= bl && ar <= br);
    oy = (au >= bd && au <= bu) || (ad >= bd && ad <= bu);
    return ox && oy;
  endfunction

  function void owe(status_code_t st, logic hp, logic [15:0] a, logic [15:0] b, logic last);
    scan_result_t r;
    r.status    = st;
    r.has_pair  = hp;
    r.first_id  = a;
    r.second_id = b;
    r.last      = last;
    owed_q = {owed_q, r};
  endfunction

  // apply one accepted input to the table and queue what it must produce
  function void note_input(opcode_t op, logic [79:0] data);
    logic [15:0] id;
    int          slot;
    int          pa[$];
    int          pb[$];
    id   = data[15:0];
    slot = find_slot(id);
    case (op)
      OP_ADD: begin
        if (slot >= 0) begin
          owe(ST_DUP, 1'b0, 16'd0, 16'd0, 1'b1);
        end else if (count >= Slots) begin
          owe(ST_FULL, 1'b0, 16'd0, 16'd0, 1'b1);
        end else begin
          ids[count]   = id;
          cen_x[count] = data[31:16];
          cen_y[count] = data[47:32];
          wid[count]   = data[63:48];
          hgt[count]   = data[79:64];
          count++;
          owe(ST_OK, 1'b0, 16'd0, 16'd0, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (slot < 0) begin
          owe(ST_NOT_FOUND, 1'b0, 16'd0, 16'd0, 1'b1);
        end else begin
          // later entries close up to keep order
          for (int i = slot; i + 1 < count; i++) begin
            ids[i]   = ids[i + 1];
            cen_x[i] = cen_x[i + 1];
            cen_y[i] = cen_y[i + 1];
            wid[i]   = wid[i + 1];
            hgt[i]   = hgt[i + 1];
          end
          count--;
          owe(ST_OK, 1'b0, 16'd0, 16'd0, 1'b1);
        end
      end
      OP_UPDATE: begin
        if (slot < 0) begin
          owe(ST_NOT_FOUND, 1'b0, 16'd0, 16'd0, 1'b1);
        end else begin
          cen_x[slot] = data[31:16];
          cen_y[slot] = data[47:32];
          owe(ST_OK, 1'b0, 16'd0, 16'd0, 1'b1);
        end
      end
      default: begin
        // every pair i<j in table order
        for (int i = 0; i < count; i++) begin
          for (int j = i + 1; j < count; j++) begin
            if (edges_in(i, j) || edges_in(j, i)) begin
              pa = {pa, i};
              pb = {pb, j};
            end
          end
        end
        if (pa.size() == 0) begin
          owe(ST_OK, 1'b0, 16'd0, 16'd0, 1'b1);
        end else begin
          for (int k = 0; k < pa.size(); k++) begin
            owe(ST_OK, 1'b1, ids[pa[k]], ids[pb[k]], k == pa.size() - 1);
          end
        end
      end
    endcase
  endfunction

  // compare one output transfer with the oldest owed result
  function void check_result(logic [39:0] data, logic [0:0] user, logic last);
    scan_result_t r;
    if (owed_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: status %0d pair %0b ids %0h/%0h last %0b",
                 data[1:0], user[0], data[17:2], data[33:18], last);
      return;
    end
    r = owed_q.pop_front();
    if (data[1:0] !== r.status || user[0] !== r.has_pair || data[17:2] !== r.first_id ||
        data[33:18] !== r.second_id || last !== r.last || data[39:34] !== 6'd0) begin
      errors++;
      if (errors <= 10)
        $display({"mismatch: expected status %0d pair %0b ids %0h/%0h last %0b, ",
                  "got status %0d pair %0b ids %0h/%0h last %0b fill %0h"},
                 r.status, r.has_pair, r.first_id, r.second_id, r.last,
                 data[1:0], user[0], data[17:2], data[33:18], last, data[39:34]);
    end
  endfunction
endclass

module tb;
  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        calm          = 1'b0;

  collider_scoreboard sb;

  aabb_collider_table_pair_scan_unit #(
    .MAX_COLLIDERS(8),
    .COORD_BITS   (16)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // result side: check every transfer, stall now and then
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 10);
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(opcode_t op, logic [15:0] id, logic [15:0] x, logic [15:0] y,
                           logic [15:0] w, logic [15:0] h);
    if (!calm) begin
      while ($urandom_range(0, 99) < 10) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {h, w, y, x, id};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(op, {h, w, y, x, id});
  endtask

  // hold the sender until every owed result has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    if ($urandom_range(0, 99) < 70) return 16'($urandom_range(0, 16'h0800) - 16'h0400);
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_size();
    if ($urandom_range(0, 99) < 70) return 16'($urandom_range(0, 16'h0600));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_id();
    int pick;
    pick = $urandom_range(0, 99);
    if (sb.count > 0 && pick < 60) return sb.ids[$urandom_range(0, sb.count - 1)];
    if (pick < 85) return 16'($urandom_range(0, 15));
    return 16'($urandom);
  endfunction

  // empty the table, then fill it with eight mutually overlapping boxes and scan
  task automatic build_pile();
    logic [15:0] victim;
    while (sb.count > 0) begin
      victim = sb.ids[$urandom_range(0, sb.count - 1)];
      send_item(OP_REMOVE, victim, rand_coord(), rand_coord(), rand_size(), rand_size());
    end
    for (int k = 0; k < 8; k++) begin
      send_item(OP_ADD, 16'(k * 4099 + $urandom_range(0, 3)),
                16'($urandom_range(0, 16'h0080) - 16'h0040),
                16'($urandom_range(0, 16'h0080) - 16'h0040),
                16'($urandom_range(16'h0400, 16'h0800)),
                16'($urandom_range(16'h0400, 16'h0800)));
    end
    send_item(OP_SCAN, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
  endtask

  // directed cases: empty table, extremes, duplicates, full table, touching
  // and nested boxes, removal at head, tail and middle, unknown ids
  task automatic run_directed();
    send_item(OP_SCAN,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_REMOVE, 16'h0005, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_UPDATE, 16'h0005, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
    send_item(OP_ADD,    16'h0000, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
    send_item(OP_ADD,    16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0100);
    send_item(OP_ADD,    16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
    send_item(OP_SCAN,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_ADD,    16'h0001, 16'h0000, 16'h0000, 16'h0200, 16'h0200);
    // right edge of id 1 meets left edge of id 2 exactly
    send_item(OP_ADD,    16'h0002, 16'h0200, 16'h0000, 16'h0200, 16'h0200);
    send_item(OP_ADD,    16'h0003, 16'h0201, 16'h0000, 16'h0200, 16'h0200);
    // fully inside id 1
    send_item(OP_ADD,    16'h0004, 16'h0000, 16'h0000, 16'h0010, 16'h0010);
    send_item(OP_ADD,    16'h0005, 16'hFF00, 16'h0100, 16'h0100, 16'h0100);
    send_item(OP_ADD,    16'h0006, 16'h0100, 16'hFE00, 16'h0040, 16'h0040);
    send_item(OP_ADD,    16'h0007, 16'h0000, 16'h0000, 16'h0100, 16'h0100);
    // duplicate wins over full
    send_item(OP_ADD,    16'h0001, 16'h0000, 16'h0000, 16'h0100, 16'h0100);
    send_item(OP_SCAN,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(OP_REMOVE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_REMOVE, 16'h0006, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_REMOVE, 16'h0002, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_REMOVE, 16'h0002, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    // size fields are ignored on update
    send_item(OP_UPDATE, 16'hFFFF, 16'h0000, 16'h0000, 16'h1234, 16'h5678);
    send_item(OP_UPDATE, 16'hABCD, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_SCAN,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
  endtask

  // stimulus and end of run
  initial begin
    int      pick;
    opcode_t op;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    wait_drained();
    repeat (4) @(posedge clk);
    build_pile();
    for (int k = 0; k < 80; k++) begin
      calm <= (k >= 25 && k < 50);
      if (k == 40) begin
        wait_drained();
        repeat (5) @(posedge clk);
      end
      if (k == 60) build_pile();
      pick = $urandom_range(0, 99);
      if (pick < 35)      op = OP_ADD;
      else if (pick < 55) op = OP_REMOVE;
      else if (pick < 75) op = OP_UPDATE;
      else                op = OP_SCAN;
      send_item(op, rand_id(), rand_coord(), rand_coord(), rand_size(), rand_size());
    end
    calm <= 1'b0;
    wait_drained();
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
